[design/extended_pdu_frame_parser_unit_assert.svh]
// Assertion macros for the extended PDU frame parser.
// Used by the top level; needs nothing but a clock and a reset signal.
`ifndef EXTENDED_PDU_FRAME_PARSER_UNIT_ASSERT_SVH
`define EXTENDED_PDU_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define EPFP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset
`define EPFP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/epfp_pkg.sv]
// Shared types and constants of the extended PDU frame parser.
// No dependencies; used by the field decoder and the top level.
package epfp_pkg;

   localparam int COUNT_W = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] MIN_EXT_LEN = COUNT_W'(9);
   localparam logic [COUNT_W-1:0] TIME_LEN    = COUNT_W'(8);
   localparam logic [COUNT_W-1:0] DIGEST_LEN  = COUNT_W'(32);

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXT_CODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXT_STREAM  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_MASK   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIGEST_MASK = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION     = 3'd4;

   // Register reset values
   localparam logic [7:0]  RST_EXT_CODE    = 8'd110;
   localparam logic [7:0]  RST_EXT_STREAM  = 8'd111;
   localparam logic [15:0] RST_TIME_MASK   = 16'd1;
   localparam logic [15:0] RST_DIGEST_MASK = 16'd2;
   localparam logic [7:0]  RST_VERSION     = 8'd1;

   typedef enum logic [3:0] {
      KIND_CODE     = 4'd0,
      KIND_STD_DATA = 4'd1,
      KIND_VERSION  = 4'd2,
      KIND_FLAGS    = 4'd3,
      KIND_CORR     = 4'd4,
      KIND_TIME     = 4'd5,
      KIND_EXT_CODE = 4'd6,
      KIND_LENGTH   = 4'd7,
      KIND_PAYLOAD  = 4'd8,
      KIND_DIGEST   = 4'd9,
      KIND_TRAILING = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_INVALID     = 2'd1,
      ST_UNSUPPORTED = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  ext_code;
      logic [7:0]  ext_stream_code;
      logic [15:0] time_mask;
      logic [15:0] digest_mask;
      logic [7:0]  version;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic               extended_seen;
      logic               version_bad;
      logic [15:0]        flags;
      logic [15:0]        correlation;
      logic [7:0]         ext_code;
      logic [15:0]        length;
   } frame_state_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    field_kind;
      logic [15:0] field_position;
      logic        frame_done;
      status_type  status;
      logic        is_extended;
      logic [15:0] flags_value;
      logic [15:0] corr_value;
      logic [7:0]  ext_function;
      logic [15:0] pay_count;
   } result_type;

endpackage

[design/extended_pdu_frame_parser_unit.sv]
// Top level of the extended PDU frame parser: CSRs, frame state and result register.
// Depends on epfp_pkg, epfp_field_decoder and the assertion macro header.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_in_byte, req_last
//   rsp      out        rsp_valid/rsp_stall  byte, field tag, status, decoded header
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One beat per cycle while req_stall is low; a result appears in the cycle after its request beat.
// The field decode runs in one pass from the frame state register to the result register.
// Reset restores CSR defaults and clears frame state; the parser then expects a first byte.
// A stalled result holds; req_stall is raised only while a result waits under rsp_stall.
// csr_ready is always high; write CSRs only while the parser is idle.
module extended_pdu_frame_parser_unit import epfp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic [3:0]             rsp_field_kind,
   output logic [15:0]            rsp_field_position,
   output logic                   rsp_frame_done,
   output logic [1:0]             rsp_status,
   output logic                   rsp_is_extended,
   output logic [15:0]            rsp_flags_value,
   output logic [15:0]            rsp_corr_value,
   output logic [7:0]             rsp_ext_function,
   output logic [15:0]            rsp_pay_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_data
);

`include "extended_pdu_frame_parser_unit_assert.svh"

   cfg_type         cfg_ff;
   frame_state_type state_ff, state_in;
   result_type      result_in, result_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ext_code        <= RST_EXT_CODE;
         cfg_ff.ext_stream_code <= RST_EXT_STREAM;
         cfg_ff.time_mask       <= RST_TIME_MASK;
         cfg_ff.digest_mask     <= RST_DIGEST_MASK;
         cfg_ff.version         <= RST_VERSION;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXT_CODE:    cfg_ff.ext_code        <= csr_data[7:0];
            CSR_EXT_STREAM:  cfg_ff.ext_stream_code <= csr_data[7:0];
            CSR_TIME_MASK:   cfg_ff.time_mask       <= csr_data;
            CSR_DIGEST_MASK: cfg_ff.digest_mask     <= csr_data;
            CSR_VERSION:     cfg_ff.version         <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   epfp_field_decoder u_decoder (
      .state_ff (state_ff),
      .cfg      (cfg_ff),
      .in_byte  (req_in_byte),
      .last     (req_last),
      .state_in (state_in),
      .result   (result_in)
   );

   // Frame state advances on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_comb begin
      if (req_accept) rsp_valid_in = 1'b1;
      else            rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = result_ff.out_byte;
   assign rsp_field_kind     = result_ff.field_kind;
   assign rsp_field_position = result_ff.field_position;
   assign rsp_frame_done     = result_ff.frame_done;
   assign rsp_status         = result_ff.status;
   assign rsp_is_extended    = result_ff.is_extended;
   assign rsp_flags_value    = result_ff.flags_value;
   assign rsp_corr_value     = result_ff.corr_value;
   assign rsp_ext_function   = result_ff.ext_function;
   assign rsp_pay_count      = result_ff.pay_count;

   // Checks
   `EPFP_ASSERT_NXT(a_clear_after_last, clock, reset, req_accept && req_last,
      state_ff.byte_count == '0, "frame state not cleared after last beat")
   `EPFP_ASSERT_NXT(a_count_steps, clock, reset, req_accept && !req_last,
      state_ff.byte_count == $past(state_ff.byte_count) + COUNT_W'(1) ||
      state_ff.byte_count == COUNT_MAX, "byte counter did not advance")
   `EPFP_ASSERT_IMP(a_mid_frame_quiet, clock, reset, rsp_valid_ff && !rsp_frame_done,
      rsp_status == ST_OK && rsp_flags_value == '0 && rsp_pay_count == '0,
      "frame report fields set on a mid-frame beat")
   `EPFP_ASSERT_IMP(a_fail_no_header, clock, reset, rsp_valid_ff && rsp_status != ST_OK,
      rsp_is_extended && rsp_ext_function == '0 && rsp_corr_value == '0,
      "failed frame reports a header or is not extended")

endmodule

[design/epfp_field_decoder.sv]
// Per-beat field decode: tags one byte, updates the frame state, builds the result.
// Purely combinational; depends on epfp_pkg.
module epfp_field_decoder import epfp_pkg::*; (
   input  frame_state_type state_ff,
   input  cfg_type         cfg,
   input  logic [7:0]      in_byte,
   input  logic            last,
   output frame_state_type state_in,
   output result_type      result
);

   localparam logic [COUNT_W-1:0] HDR_BASE = COUNT_W'(6);
   localparam logic [COUNT_W-1:0] LEN_OFS  = COUNT_W'(3);

   logic [COUNT_W-1:0] idx;
   logic               ext_now;
   logic [COUNT_W-1:0] base, len_end, pend, dend;
   logic [COUNT_W-1:0] pos_raw;
   kind_type           kind;
   frame_state_type    upd;
   logic [COUNT_W-1:0] cnt_next;
   logic [COUNT_W-1:0] base_n, hdr_end_n, pay_end_n, dig_end_n;
   status_type         ext_status;

   assign idx = state_ff.byte_count;

   // Extended layout boundaries from the state before this byte
   always_comb begin
      base    = (|(state_ff.flags & cfg.time_mask)) ? HDR_BASE + TIME_LEN : HDR_BASE;
      len_end = base + LEN_OFS;
      pend    = len_end + {1'b0, state_ff.length};
      dend    = (|(state_ff.flags & cfg.digest_mask)) ? pend + DIGEST_LEN : pend;
   end

   // Frame kind: the first byte decides it
   assign ext_now = (idx == '0) ? ((in_byte == cfg.ext_code) ||
                                   (in_byte == cfg.ext_stream_code))
                                : state_ff.extended_seen;

   // Field tag and raw position
   always_comb begin
      pos_raw = '0;
      if (!ext_now) begin
         if (idx == '0) begin
            kind = KIND_CODE;
         end else begin
            kind    = KIND_STD_DATA;
            pos_raw = idx - COUNT_W'(1);
         end
      end else begin
         priority if (idx == '0) begin
            kind = KIND_CODE;
         end else if (idx == COUNT_W'(1)) begin
            kind = KIND_VERSION;
         end else if (idx < COUNT_W'(4)) begin
            kind    = KIND_FLAGS;
            pos_raw = idx - COUNT_W'(2);
         end else if (idx < HDR_BASE) begin
            kind    = KIND_CORR;
            pos_raw = idx - COUNT_W'(4);
         end else if (idx < base) begin
            kind    = KIND_TIME;
            pos_raw = idx - HDR_BASE;
         end else if (idx == base) begin
            kind = KIND_EXT_CODE;
         end else if (idx < len_end) begin
            kind    = KIND_LENGTH;
            pos_raw = idx - base - COUNT_W'(1);
         end else if (idx < pend) begin
            kind    = KIND_PAYLOAD;
            pos_raw = idx - len_end;
         end else if (idx < dend) begin
            kind    = KIND_DIGEST;
            pos_raw = idx - pend;
         end else begin
            kind    = KIND_TRAILING;
            pos_raw = idx - dend;
         end
      end
   end

   // Header capture, big-endian words
   always_comb begin
      upd               = state_ff;
      upd.extended_seen = ext_now;
      if (ext_now) begin
         unique case (kind)
            KIND_VERSION:  upd.version_bad = (in_byte != cfg.version);
            KIND_FLAGS: begin
               if (pos_raw == '0) upd.flags[15:8] = in_byte;
               else               upd.flags[7:0]  = in_byte;
            end
            KIND_CORR: begin
               if (pos_raw == '0) upd.correlation[15:8] = in_byte;
               else               upd.correlation[7:0]  = in_byte;
            end
            KIND_EXT_CODE: upd.ext_code = in_byte;
            KIND_LENGTH: begin
               if (pos_raw == '0) upd.length[15:8] = in_byte;
               else               upd.length[7:0]  = in_byte;
            end
            default: ;
         endcase
      end
      cnt_next       = (idx == COUNT_MAX) ? idx : idx + COUNT_W'(1);
      upd.byte_count = cnt_next;
   end

   // Frame status, from the header as it stands after this byte
   always_comb begin
      base_n    = (|(upd.flags & cfg.time_mask)) ? HDR_BASE + TIME_LEN : HDR_BASE;
      hdr_end_n = base_n + LEN_OFS;
      pay_end_n = hdr_end_n + {1'b0, upd.length};
      dig_end_n = pay_end_n + DIGEST_LEN;
      priority if (cnt_next < MIN_EXT_LEN) begin
         ext_status = ST_INVALID;
      end else if (upd.version_bad) begin
         ext_status = ST_UNSUPPORTED;
      end else if (cnt_next < hdr_end_n || cnt_next < pay_end_n) begin
         ext_status = ST_INVALID;
      end else if ((|(upd.flags & cfg.digest_mask)) && cnt_next < dig_end_n) begin
         ext_status = ST_INVALID;
      end else begin
         ext_status = ST_OK;
      end
   end

   // Result beat and next frame state
   always_comb begin
      result                = '0;
      result.out_byte       = in_byte;
      result.field_kind     = kind;
      result.field_position = pos_raw[COUNT_W-1] ? 16'hFFFF : pos_raw[15:0];
      result.status         = ST_OK;
      state_in              = upd;
      if (last) begin
         result.frame_done  = 1'b1;
         result.is_extended = ext_now;
         result.status      = ext_now ? ext_status : ST_OK;
         if (ext_now && ext_status == ST_OK) begin
            result.flags_value  = upd.flags;
            result.corr_value   = upd.correlation;
            result.ext_function = upd.ext_code;
            result.pay_count    = upd.length;
         end
         state_in = '0;
      end
   end

endmodule
